FILE: rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Types and constants shared by the TCP segment checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned PDATA_W   = 32;
  // running total of eight 16-bit words before folding
  localparam int unsigned WIDE_W    = WORD_W + 3;

  localparam logic [WORD_W-1:0] TCP_PROTOCOL = 16'd6;
  localparam logic [WORD_W-1:0] WORD_MAX     = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_SRC_IP  = 1'b0;
  localparam logic REG_DEST_IP = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } tsc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] checksum;
    logic              verify_ok;
    logic              length_overflow;
  } tsc_out_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
  } tsc_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcp_segment_checksum.sv
// ----------------------------------------------------------------------------
// tcp_segment_checksum
// TCP checksum with IPv4 pseudo-header over a byte stream of one segment.
// The last byte's sum goes from the input register into the result register.
// Throughput: one byte per cycle; the byte path stalls only while a finished
//   result sits in the output register and the sink is stalling it.
// Reset (rst, synchronous): clears both pipeline valids, the segment state
//   and the two address registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_segment_checksum import tsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // byte stream in
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire tsc_in_t            byte_data,
  // checksum result out
  output logic                    sum_valid,
  input  wire logic               sum_stall,
  output tsc_out_t                sum_data,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  tsc_cfg_t cfg;
  tsc_out_t core_result;

  // input register stage
  logic    s1_valid;
  tsc_in_t s1_item;

  logic    byte_accept;
  logic    out_free;
  logic    s1_move;
  logic    out_load;

  tsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Output slot is free when empty or being drained this cycle.
  assign out_free    = !sum_valid || !sum_stall;
  // A non-last byte only updates state, so it never waits on the output.
  assign s1_move     = s1_valid && (!s1_item.last_byte || out_free);
  assign out_load    = s1_move && s1_item.last_byte;
  assign byte_stall  = s1_valid && !s1_move;
  assign byte_accept = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      s1_item <= byte_data;
    end
  end

  // State updates and closing sum happen between the two registers.
  tsc_sum_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_move),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (out_load) begin
      sum_valid <= 1'b1;
    end else if (!sum_stall) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sum_data <= core_result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tsc_cfg_regs
// APB register file holding the pseudo-header IPv4 addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_cfg_regs import tsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output tsc_cfg_t                cfg
);

  logic [31:0] src_ip;
  logic [31:0] dest_ip;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_ip  <= '0;
      dest_ip <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SRC_IP:  src_ip  <= pwdata;
        REG_DEST_IP: dest_ip <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SRC_IP:  prdata = src_ip;
      REG_DEST_IP: prdata = dest_ip;
      default:     prdata = '0;
    endcase
  end

  assign cfg = '{src_ip: src_ip, dest_ip: dest_ip};

endmodule

`default_nettype wire

FILE: rtl/core/tsc_sum_core.sv
// ----------------------------------------------------------------------------
// tsc_sum_core
// Per-segment state: byte pairing, one's-complement accumulate, byte count,
// and the closing pseudo-header sum for the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_sum_core import tsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire tsc_in_t  item,
  input  wire tsc_cfg_t cfg,
  output tsc_out_t      result
);

  logic [WORD_W-1:0] running_sum;
  logic [BYTE_W-1:0] held_high_byte;
  logic              odd_phase;
  logic [WORD_W-1:0] byte_count;
  logic              count_saturated;

  logic [WORD_W-1:0] byte_count_next;
  logic              count_saturated_next;
  logic              add_en;
  logic [WORD_W-1:0] word;
  logic [WORD_W:0]   pair_sum;
  logic [WORD_W-1:0] running_sum_next;
  logic [WIDE_W-1:0] total;
  logic [WORD_W:0]   fold1;
  logic [WORD_W-1:0] fold2;

  always_comb begin
    count_saturated_next = count_saturated || (byte_count == WORD_MAX);
    byte_count_next      = (byte_count == WORD_MAX) ? byte_count : byte_count + 1'b1;

    if (odd_phase) begin
      add_en = 1'b1;
      word   = {held_high_byte, item.data_byte};
    end else if (item.last_byte) begin
      add_en = 1'b1;
      word   = {item.data_byte, {BYTE_W{1'b0}}};
    end else begin
      add_en = 1'b0;
      word   = '0;
    end

    // end-around carry add for the running word sum
    pair_sum         = {1'b0, running_sum} + {1'b0, word};
    running_sum_next = pair_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, pair_sum[WORD_W]};

    // closing sum: wide add of all terms, then two folds
    total = {3'b000, running_sum}
          + {3'b000, word}
          + {3'b000, cfg.src_ip[31:16]}
          + {3'b000, cfg.src_ip[15:0]}
          + {3'b000, cfg.dest_ip[31:16]}
          + {3'b000, cfg.dest_ip[15:0]}
          + {3'b000, TCP_PROTOCOL}
          + {3'b000, byte_count_next};
    fold1 = {1'b0, total[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, total[WIDE_W-1:WORD_W]};
    fold2 = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};

    result.checksum        = ~fold2;
    result.verify_ok       = (fold2 == WORD_MAX);
    result.length_overflow = count_saturated_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      held_high_byte  <= '0;
      odd_phase       <= 1'b0;
      byte_count      <= '0;
      count_saturated <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        running_sum     <= '0;
        held_high_byte  <= '0;
        odd_phase       <= 1'b0;
        byte_count      <= '0;
        count_saturated <= 1'b0;
      end else begin
        byte_count      <= byte_count_next;
        count_saturated <= count_saturated_next;
        if (add_en) begin
          running_sum    <= running_sum_next;
          held_high_byte <= '0;
          odd_phase      <= 1'b0;
        end else begin
          held_high_byte <= item.data_byte;
          odd_phase      <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks for tcp_segment_checksum, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_checker import tsc_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     byte_valid,
  input wire logic     byte_stall,
  input wire tsc_in_t  byte_data,
  input wire logic     sum_valid,
  input wire logic     sum_stall,
  input wire tsc_out_t sum_data
);

  // no result straight out of reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !sum_valid)
    else $error("result valid after reset");

  // byte path only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (sum_valid && sum_stall))
    else $error("byte stall without a stalled result");

  // stalled byte beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_stall) |=> (byte_valid && $stable(byte_data)))
    else $error("stalled byte beat dropped or changed");

  // verify flag agrees with checksum value
  a_verify_flag: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (sum_data.verify_ok == (sum_data.checksum == 16'h0000)))
    else $error("verify_ok disagrees with checksum");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && sum_stall) |=> (sum_valid && $stable(sum_data)))
    else $error("stalled result dropped or changed");

endmodule

bind tcp_segment_checksum tsc_checker u_tsc_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_data  (byte_data),
  .sum_valid  (sum_valid),
  .sum_stall  (sum_stall),
  .sum_data   (sum_data)
);

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TCP segment checksum block. Segments go in as
// byte beats with random gaps and come out as checksum beats behind random
// sink stalls. An in-bench model of the one's-complement sum with the IPv4
// pseudo-header predicts each result. The source and destination addresses
// are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_top import tsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_BEATS  = 163;
  localparam int unsigned DRAIN_CYCLES = 8;

  // directed stimulus row: one byte beat, with a hand-computed result on
  // rows where the sum is obvious (addresses still at their reset value)
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fixed;
    tsc_out_t          want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // single zero byte: only protocol and length 1 in the sum
    '{8'h00, 1'b1, 1'b1, '{16'hFFF8, 1'b0, 1'b0}},
    // single odd byte becomes the high byte of a padded word
    '{8'hFF, 1'b1, 1'b1, '{16'h00F8, 1'b0, 1'b0}},
    // all-ones word plus protocol wraps through the end-around carry
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{16'hFFF7, 1'b0, 1'b0}},
    // word chosen so the folded sum is all ones: segment verifies
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hF7, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    // all-zero word lands on the same checksum as the wrapped one
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{16'hFFF7, 1'b0, 1'b0}},
    // odd-length segment, padded last byte
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b0, '0},
    // even-length mixed pattern
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b0, '0},
    '{8'hC3, 1'b1, 1'b0, '0},
    // walking one through byte bits 0 to 6
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h10, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b0, '0},
    '{8'h40, 1'b1, 1'b0, '0}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  tsc_in_t            byte_data = '0;
  logic               sum_valid;
  logic               sum_stall = 1'b0;
  tsc_out_t           sum_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tcp_segment_checksum u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .sum_valid  (sum_valid),
    .sum_stall  (sum_stall),
    .sum_data   (sum_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Checksum model state: mirrors the block's segment accumulator and the two
  // address registers. Checksum beats still owed by the block queue up here.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] sum_acc;
  logic [BYTE_W-1:0] held_hi;
  logic              odd_half;
  logic [WORD_W-1:0] seg_len;
  logic              len_sat;
  logic [31:0]       src_ip;
  logic [31:0]       dst_ip;

  tsc_out_t pending_sums[$];

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned beats_sent  = 0;
  int unsigned sink_hold   = 0;
  bit          sink_quiet  = 1'b0;

  // one's-complement add with end-around carry
  function automatic logic [WORD_W-1:0] fold_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] t;
    t = a + b;
    return t[WORD_W-1:0] + t[WORD_W];
  endfunction

  function automatic void clear_segment();
    sum_acc  = '0;
    held_hi  = '0;
    odd_half = 1'b0;
    seg_len  = '0;
    len_sat  = 1'b0;
  endfunction

  // Feed one accepted byte into the model; on the last byte, fold in the
  // pseudo-header and hand back the checksum beat the block must produce.
  task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic last,
                             output bit done, output tsc_out_t res);
    logic [WORD_W-1:0] s;
    done = 1'b0;
    res  = '0;
    // length saturates at 65535; the byte past that sets the overflow flag
    if (seg_len == WORD_MAX) len_sat = 1'b1;
    else seg_len = seg_len + 1'b1;
    if (!odd_half) begin
      if (last) begin
        sum_acc = fold_add(sum_acc, {b, 8'h00});
      end else begin
        held_hi  = b;
        odd_half = 1'b1;
      end
    end else begin
      sum_acc  = fold_add(sum_acc, {held_hi, b});
      held_hi  = '0;
      odd_half = 1'b0;
    end
    if (last) begin
      s = fold_add(sum_acc, src_ip[31:16]);
      s = fold_add(s, src_ip[15:0]);
      s = fold_add(s, dst_ip[31:16]);
      s = fold_add(s, dst_ip[15:0]);
      s = fold_add(s, TCP_PROTOCOL);
      s = fold_add(s, seg_len);
      res.checksum        = ~s;
      res.verify_ok       = (s == WORD_MAX);
      res.length_overflow = len_sat;
      done = 1'b1;
      clear_segment();
    end
  endtask

  // Sender-side checksum over a whole segment, used to build segments that
  // carry a correct checksum field and therefore must verify.
  function automatic logic [WORD_W-1:0] sender_checksum(input logic [BYTE_W-1:0] seg[$]);
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] len;
    s   = '0;
    len = (seg.size() > WORD_MAX) ? WORD_MAX : WORD_W'(seg.size());
    for (int i = 0; i < seg.size(); i += 2)
      s = fold_add(s, {seg[i], (i + 1 < seg.size()) ? seg[i+1] : 8'h00});
    s = fold_add(s, src_ip[31:16]);
    s = fold_add(s, src_ip[15:0]);
    s = fold_add(s, dst_ip[31:16]);
    s = fold_add(s, dst_ip[15:0]);
    s = fold_add(s, TCP_PROTOCOL);
    s = fold_add(s, len);
    return ~s;
  endfunction

  // --------------------------------------------------------------------------
  // Byte source. Every task starts at a falling edge, so valid is lowered or
  // kept high with a single assignment per time step.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input int unsigned gap, input bit fixed, input tsc_out_t want);
    bit       done;
    tsc_out_t res;
    @(negedge clk);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid          <= 1'b1;
    byte_data.data_byte <= b;
    byte_data.last_byte <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    // beat accepted at this edge
    beats_sent++;
    absorb_byte(b, last, done, res);
    if (done) pending_sums.push_back(fixed ? want : res);
  endtask

  task automatic send_segment(input logic [BYTE_W-1:0] seg[$], input bit quiet);
    for (int i = 0; i < seg.size(); i++)
      send_byte(seg[i], i == seg.size() - 1, quiet ? 0 : $urandom_range(0, 14), 1'b0, '0);
  endtask

  // drop valid and let every owed checksum beat drain, plus the pipeline tail
  task automatic drain();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup phase, then access phase until pready.
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic reg_sel,
                            input logic [PDATA_W-1:0] wdata, input logic [PDATA_W-1:0] rexp);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== rexp) begin
      $error("prdata reg %0d: expected %h, got %h", reg_sel, rexp, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // program both addresses while idle, then read them back
  task automatic set_addresses(input logic [31:0] s, input logic [31:0] d);
    drain();
    apb_access(1'b1, REG_SRC_IP, s, '0);
    apb_access(1'b1, REG_DEST_IP, d, '0);
    src_ip = s;
    dst_ip = d;
    apb_access(1'b0, REG_SRC_IP, '0, s);
    apb_access(1'b0, REG_DEST_IP, '0, d);
  endtask

  // --------------------------------------------------------------------------
  // Checksum sink: stalls a freshly presented beat for a drawn number of
  // cycles; the count is redrawn after each accepted beat.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sum_valid && sink_hold != 0) begin
      sum_stall <= 1'b1;
      sink_hold--;
    end else begin
      sum_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted checksum beat with the oldest owed one.
  always @(posedge clk) begin
    tsc_out_t exp_sum;
    if (!rst && sum_valid && !sum_stall) begin
      if (pending_sums.size() == 0) begin
        $error("checksum beat with none owed: %h", sum_data);
        errors++;
      end else begin
        exp_sum = pending_sums.pop_front();
        if (sum_data.checksum !== exp_sum.checksum) begin
          $error("checksum: expected %h, got %h", exp_sum.checksum, sum_data.checksum);
          errors++;
        end
        if (sum_data.verify_ok !== exp_sum.verify_ok) begin
          $error("verify_ok: expected %b, got %b", exp_sum.verify_ok, sum_data.verify_ok);
          errors++;
        end
        if (sum_data.length_overflow !== exp_sum.length_overflow) begin
          $error("length_overflow: expected %b, got %b",
                 exp_sum.length_overflow, sum_data.length_overflow);
          errors++;
        end
      end
      sink_hold = sink_quiet ? 0 : $urandom_range(0, 14);
    end
  end

  // Watchdog on total run time.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [BYTE_W-1:0] seg[$];
    logic [31:0]       s_ip;
    logic [31:0]       d_ip;
    logic [WORD_W-1:0] ck;
    int unsigned       len;
    int unsigned       slot;
    int unsigned       phase_start;
    bit                quiet;

    clear_segment();
    src_ip = '0;
    dst_ip = '0;
    sink_hold = $urandom_range(0, 14);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // both address registers come out of reset as zero
    apb_access(1'b0, REG_SRC_IP, '0, '0);
    apb_access(1'b0, REG_DEST_IP, '0, '0);

    // directed table, addresses at zero
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIR_TABLE[i].data, DIR_TABLE[i].last, $urandom_range(0, 14),
                DIR_TABLE[i].fixed, DIR_TABLE[i].want);

    // random phases: address extremes first, then random addresses
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin s_ip = '1; d_ip = '1; end
        1: begin s_ip = '1; d_ip = '0; end
        2: begin s_ip = '0; d_ip = '1; end
        3: begin s_ip = '0; d_ip = '0; end
        default: begin s_ip = $urandom(); d_ip = $urandom(); end
      endcase
      set_addresses(s_ip, d_ip);
      // some phases run the sink without stalls
      sink_quiet  = (p % 3 == 2);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        seg.delete();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++) seg.push_back(BYTE_W'($urandom_range(0, 255)));
        // about a quarter of the segments carry a correct checksum field
        if (len >= 2 && $urandom_range(0, 3) == 0) begin
          slot = (len >= 18) ? 16 : 0;
          seg[slot]     = '0;
          seg[slot + 1] = '0;
          ck = sender_checksum(seg);
          seg[slot]     = ck[15:8];
          seg[slot + 1] = ck[7:0];
        end
        quiet = ($urandom_range(0, 3) == 0);
        send_segment(seg, quiet);
      end
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
